// File: sv/tgpg_pkg.sv
// Shared types, constants and the cosine table builder for the trot gait generator.
package tgpg_pkg;

  // Quarter-wave cosine table depth and the index widths that follow from it
  localparam int COS_DEPTH = 256;
  localparam int CosJW     = $clog2(COS_DEPTH);
  localparam int CosIdxW   = $clog2(COS_DEPTH + 1);
  localparam int JProdW    = 14 + CosIdxW;

  // Q4.60 constants for the table series
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;
  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;

  // Phase value for one half turn (Q0.16)
  localparam logic [15:0] HALF_TURN = 16'h8000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HIP_AMP   = 3'd0,
    CFG_HIP_OFF   = 3'd1,
    CFG_KNEE_AMP  = 3'd2,
    CFG_KNEE_OFF  = 3'd3,
    CFG_GAIT_FREQ = 3'd4
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [14:0] HIP_AMP_RST   = 15'd1229;
  localparam logic [15:0] HIP_OFF_RST   = 16'd0;
  localparam logic [14:0] KNEE_AMP_RST  = 15'd1638;
  localparam logic [15:0] KNEE_OFF_RST  = 16'd2458;
  localparam logic [15:0] GAIT_FREQ_RST = 16'd128;

  // Register values seen by the pipeline
  typedef struct packed {
    logic        [14:0] hip_amp;
    logic signed [15:0] hip_off;
    logic        [14:0] knee_amp;
    logic signed [15:0] knee_off;
    logic        [15:0] gait_freq;
  } cfg_t;

  // Phase stage -> table stage
  typedef struct packed {
    logic               valid;
    logic [CosIdxW-1:0] idx;
    logic               neg;
    logic               first;
  } phase_t;

  // Table stage -> joint stage
  typedef struct packed {
    logic               valid;
    logic signed [15:0] cos;
    logic               first;
  } cosv_t;

  // Table entry k: round(16384 * cos(pi/2 * k / depth)), entry depth reads 0
  function automatic logic [14:0] cos_entry(input int unsigned k);
    logic [63:0]        step_q;
    logic [63:0]        step_r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        sum;
    logic [127:0]       pr;
    logic [63:0]        rnd;
    step_q = HALF_PI_Q60 / COS_DEPTH;
    step_r = HALF_PI_Q60 % COS_DEPTH;
    x      = step_q * 64'(k) + (step_r * 64'(k)) / COS_DEPTH;
    pr     = {64'd0, x} * {64'd0, x};
    x2     = pr[123:60];
    term   = ONE_Q60;
    sum    = ONE_Q60;
    for (int n = 1; n <= 14; n++) begin
      pr   = {64'd0, term} * {64'd0, x2};
      term = pr[123:60] / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum[63]) begin
      sum = 64'd0;
    end
    rnd = (sum + (64'd1 << 45)) >> 46;
    if (k >= COS_DEPTH) begin
      return 15'd0;
    end
    return rnd[14:0];
  endfunction

  // Clamp a 20-bit signed sum to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7FFF;
    end
    if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// File: sv/tgpg_if.sv
// Request channel interfaces: time stamp in, joint commands out.
interface tgpg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_stamp;

  modport source (output valid, output time_stamp, input ready);
  modport sink   (input valid, input time_stamp, output ready);
endinterface

interface tgpg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] lf_hip;
  logic signed [15:0] rf_hip;
  logic signed [15:0] lh_hip;
  logic signed [15:0] rh_hip;
  logic signed [15:0] lf_knee;
  logic signed [15:0] rf_knee;
  logic signed [15:0] lh_knee;
  logic signed [15:0] rh_knee;

  modport source (output valid, input ready,
                  output lf_hip, rf_hip, lh_hip, rh_hip,
                  output lf_knee, rf_knee, lh_knee, rh_knee);
  modport sink   (input valid, output ready,
                  input lf_hip, rf_hip, lh_hip, rh_hip,
                  input lf_knee, rf_knee, lh_knee, rh_knee);
endinterface

// File: sv/tgpg_phase.sv
// Stages 1-2: gait phase from time times frequency, then table index and quadrant.
module tgpg_phase
  import tgpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] time_stamp,
  input  logic [15:0] gait_freq,
  output phase_t      ph
);

  logic        v1_r;
  logic [15:0] p_r;
  logic [23:0] prod;
  phase_t      ph_r;
  phase_t      ph_nxt;
  logic [JProdW-1:0] jprod;
  logic [CosJW-1:0]  j;
  logic [1:0]        q;

  // Only product bits 23:8 land in the phase, so the low 24 bits suffice
  assign prod = time_stamp[23:0] * 24'(gait_freq);

  // Quadrant and position within it scaled to the table depth
  assign q     = p_r[15:14];
  assign jprod = JProdW'(p_r[13:0]) * JProdW'(COS_DEPTH);
  assign j     = CosJW'(jprod >> 14);

  always_comb begin
    ph_nxt.valid = v1_r;
    ph_nxt.first = (p_r <= HALF_TURN);
    ph_nxt.neg   = q[1] ^ q[0];
    ph_nxt.idx   = q[0] ? (CosIdxW'(COS_DEPTH) - CosIdxW'(j)) : CosIdxW'(j);
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      ph_r.valid <= 1'b0;
    end else if (adv) begin
      v1_r       <= in_valid;
      ph_r.valid <= ph_nxt.valid;
    end
    if (adv) begin
      p_r        <= prod[23:8];
      ph_r.idx   <= ph_nxt.idx;
      ph_r.neg   <= ph_nxt.neg;
      ph_r.first <= ph_nxt.first;
    end
  end

  assign ph = ph_r;

endmodule

// File: sv/tgpg_cos_lut.sv
// Stage 3: quarter-wave cosine table read and sign fold.
module tgpg_cos_lut
  import tgpg_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  phase_t ph,
  output cosv_t  cv
);

  logic [14:0] rom_tbl [COS_DEPTH+1];
  logic [15:0] mag;
  cosv_t       cv_r;

  // Constant table, one extra zero entry for the quarter edge
  for (genvar k = 0; k <= COS_DEPTH; k++) begin : g_rom
    assign rom_tbl[k] = cos_entry(k);
  end

  assign mag = {1'b0, rom_tbl[ph.idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r.valid <= 1'b0;
    end else if (adv) begin
      cv_r.valid <= ph.valid;
    end
    if (adv) begin
      cv_r.cos   <= ph.neg ? -$signed(mag) : $signed(mag);
      cv_r.first <= ph.first;
    end
  end

  assign cv = cv_r;

endmodule

// File: sv/tgpg_joint.sv
// Stages 4-5: hip amplitude multiply, then rounding, offsets, saturation, output register.
module tgpg_joint
  import tgpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  cosv_t             cv,
  input  cfg_t              cfg,
  tgpg_out_if.source        out_chan
);

  logic               v4_r;
  logic signed [31:0] m_r;
  logic               first4_r;
  logic signed [31:0] amp_x;
  logic signed [31:0] cos_x;
  logic signed [31:0] pos_full;
  logic signed [31:0] neg_full;
  logic signed [17:0] pos_rnd;
  logic signed [17:0] neg_rnd;
  logic signed [19:0] hip_pos_sum;
  logic signed [19:0] hip_neg_sum;
  logic signed [19:0] knee_sum;
  logic signed [15:0] hip_pos;
  logic signed [15:0] hip_neg;
  logic signed [15:0] knee_up;
  logic               out_valid_r;
  logic signed [15:0] lf_hip_r, rf_hip_r, lh_hip_r, rh_hip_r;
  logic signed [15:0] lf_knee_r, rf_knee_r, lh_knee_r, rh_knee_r;

  // Stage 4 operands
  assign amp_x = 32'($signed({1'b0, cfg.hip_amp}));
  assign cos_x = 32'(cv.cos);

  // Stage 5: round half up from the product with the Q1.14 cosine, add offsets, clamp
  assign pos_full    = (m_r + 32'sd8192) >>> 14;
  assign neg_full    = (32'sd8192 - m_r) >>> 14;
  assign pos_rnd     = pos_full[17:0];
  assign neg_rnd     = neg_full[17:0];
  assign hip_pos_sum = 20'(cfg.hip_off) + 20'(pos_rnd);
  assign hip_neg_sum = 20'(cfg.hip_off) + 20'(neg_rnd);
  assign knee_sum    = 20'(cfg.knee_off) + 20'($signed({1'b0, cfg.knee_amp}));
  assign hip_pos     = sat16(hip_pos_sum);
  assign hip_neg     = sat16(hip_neg_sum);
  assign knee_up     = sat16(knee_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v4_r        <= cv.valid;
      out_valid_r <= v4_r;
    end
    if (adv) begin
      m_r       <= amp_x * cos_x;
      first4_r  <= cv.first;
      lf_hip_r  <= hip_pos;
      rh_hip_r  <= hip_pos;
      rf_hip_r  <= hip_neg;
      lh_hip_r  <= hip_neg;
      // first half turn lifts right fore and left hind knees
      lf_knee_r <= first4_r ? cfg.knee_off : knee_up;
      rh_knee_r <= first4_r ? cfg.knee_off : knee_up;
      rf_knee_r <= first4_r ? knee_up : cfg.knee_off;
      lh_knee_r <= first4_r ? knee_up : cfg.knee_off;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.lf_hip  = lf_hip_r;
  assign out_chan.rf_hip  = rf_hip_r;
  assign out_chan.lh_hip  = lh_hip_r;
  assign out_chan.rh_hip  = rh_hip_r;
  assign out_chan.lf_knee = lf_knee_r;
  assign out_chan.rf_knee = rf_knee_r;
  assign out_chan.lh_knee = lh_knee_r;
  assign out_chan.rh_knee = rh_knee_r;

endmodule

// File: sv/trot_gait_pattern_generator_unit.sv
// Top level of the trot gait generator: configuration registers and pipeline control.
//
// Usage:
//   in_chan  : one request per time stamp (Q16.16 s), valid/ready handshake.
//   out_chan : one request per time stamp with four hip and four knee commands
//              (Q3.12, saturated); diagonal legs move together.
//   cfg_*    : write enable, register index and 16-bit data; the user must see that they
//              are written only while no request is in flight, which the block does not enforce.
// Pipeline: an accepted time stamp passes through registered stages for phase multiply,
//   index scaling, table read, amplitude multiply and round/offset/saturate.
// Throughput: one time stamp per cycle while the output is not stalled; every
//   stage is a register that moves as a whole.
// Stall: the whole pipeline holds while out_chan.valid is high and
//   out_chan.ready low; in_chan.ready is low in those cycles, so nothing is
//   dropped or repeated. A held result stays stable.
// Reset: synchronous, active low; clears all valid bits and loads the
//   default gait (0.3 rad hip swing, 0.4 rad knee step, 0.6 rad knee offset,
//   0.5 Hz).
module trot_gait_pattern_generator_unit
  import tgpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tgpg_in_if.sink     in_chan,
  tgpg_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t   cfg_r;
  logic   adv;
  phase_t ph;
  cosv_t  cv;

  // Pipeline moves when the output register is empty or being taken
  assign adv           = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = adv;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hip_amp   <= HIP_AMP_RST;
      cfg_r.hip_off   <= HIP_OFF_RST;
      cfg_r.knee_amp  <= KNEE_AMP_RST;
      cfg_r.knee_off  <= KNEE_OFF_RST;
      cfg_r.gait_freq <= GAIT_FREQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HIP_AMP:   cfg_r.hip_amp   <= cfg_data[14:0];
        CFG_HIP_OFF:   cfg_r.hip_off   <= cfg_data;
        CFG_KNEE_AMP:  cfg_r.knee_amp  <= cfg_data[14:0];
        CFG_KNEE_OFF:  cfg_r.knee_off  <= cfg_data;
        CFG_GAIT_FREQ: cfg_r.gait_freq <= cfg_data;
        default: ;
      endcase
    end
  end

  tgpg_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_chan.valid),
    .time_stamp (in_chan.time_stamp),
    .gait_freq  (cfg_r.gait_freq),
    .ph         (ph)
  );

  tgpg_cos_lut u_cos (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ph    (ph),
    .cv    (cv)
  );

  tgpg_joint u_joint (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cv       (cv),
    .cfg      (cfg_r),
    .out_chan (out_chan)
  );

endmodule
